// File: sv/json_syntax_validator_core_assert.svh
// Assertion macros used by the checker file.
`ifndef JSON_SYNTAX_VALIDATOR_CORE_ASSERT_SVH
`define JSON_SYNTAX_VALIDATOR_CORE_ASSERT_SVH

// Antecedent holds in a cycle, consequent in the same cycle.
`define JSV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent holds in a cycle, consequent in the next cycle.
`define JSV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/jsv_pkg.sv
package jsv_pkg;

  localparam int MAX_DEPTH_DEF = 8;
  localparam int MODE_W = 23;

  typedef enum logic [MODE_W-1:0] {
    MD_TOP       = 23'd1 << 0,
    MD_VAL       = 23'd1 << 1,
    MD_ARR_FIRST = 23'd1 << 2,
    MD_OBJ_FIRST = 23'd1 << 3,
    MD_OBJ_KEY   = 23'd1 << 4,
    MD_COLON     = 23'd1 << 5,
    MD_AFTER     = 23'd1 << 6,
    MD_DONE      = 23'd1 << 7,
    MD_STR_VAL   = 23'd1 << 8,
    MD_STR_KEY   = 23'd1 << 9,
    MD_ESC_VAL   = 23'd1 << 10,
    MD_ESC_KEY   = 23'd1 << 11,
    MD_HEX_VAL   = 23'd1 << 12,
    MD_HEX_KEY   = 23'd1 << 13,
    MD_LIT       = 23'd1 << 14,
    MD_N_MINUS   = 23'd1 << 15,
    MD_N_ZERO    = 23'd1 << 16,
    MD_N_INT     = 23'd1 << 17,
    MD_N_DOT     = 23'd1 << 18,
    MD_N_FRAC    = 23'd1 << 19,
    MD_N_EXP     = 23'd1 << 20,
    MD_N_EXPSIGN = 23'd1 << 21,
    MD_N_EXPDIG  = 23'd1 << 22
  } mode_t;

  typedef enum logic [1:0] {
    LIT_TRUE  = 2'd0,
    LIT_FALSE = 2'd1,
    LIT_NULL  = 2'd2
  } lit_kind_t;

  typedef struct packed {
    mode_t       mode;
    logic [2:0]  sub;
    lit_kind_t   lit;
    logic        failed;
  } pstate_t;

  // container kind: 1 object, 0 array
  typedef struct packed {
    logic push;
    logic pop;
    logic kind;
  } stk_ctl_t;

  localparam pstate_t PSTATE_RST = '{mode: MD_TOP, sub: 3'd0, lit: LIT_TRUE, failed: 1'b0};

endpackage

// File: sv/json_syntax_validator_core.sv
// JSON well-formedness checker, one document byte per input beat.
// Input stream: s_tdata[7:0] is the document byte, s_tlast marks the final
// byte of a document. Output stream: one beat per document, sent for the
// beat that carried s_tlast; m_tdata[0] is 1 when the document is
// well-formed JSON, bits 7:1 are zero.
// Throughput: one byte per cycle. Each byte updates the parser state,
// nesting level and container stack in the cycle it is accepted; the
// stack is a shift line, so push and pop need no memory port.
// Latency: the result beat is valid in the cycle after the last byte is
// accepted. Documents nested deeper than MAX_DEPTH + 1 are rejected.
// After the last byte the parser returns to its start state, so the next
// byte begins a new document with no gap.
// The result sits in an output register; while it waits for m_tready,
// s_tready stays low, otherwise input is taken every cycle.
// Reset (rst, synchronous) empties the output register and restarts the
// parser; the container stack needs no clearing.
module json_syntax_validator_core #(
  parameter int MAX_DEPTH = jsv_pkg::MAX_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,   // last
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [0] valid_res, [7:1] zero
);
  import jsv_pkg::*;

  localparam int LVL_W = $clog2(MAX_DEPTH + 2);

  pstate_t          st;
  pstate_t          st_next;
  logic [LVL_W-1:0] level;
  logic [LVL_W-1:0] level_next;
  stk_ctl_t         stk;
  stk_ctl_t         stk_gated;
  logic             top_kind;
  logic             accept;
  logic             doc_ok;
  logic             res_bit;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  jsv_parse #(.MAX_DEPTH(MAX_DEPTH)) u_parse (
    .st         (st),
    .level      (level),
    .top_kind   (top_kind),
    .c          (s_tdata),
    .st_next    (st_next),
    .level_next (level_next),
    .stk        (stk)
  );

  assign stk_gated = '{push: stk.push && accept, pop: stk.pop && accept, kind: stk.kind};

  jsv_stack #(.MAX_DEPTH(MAX_DEPTH)) u_stack (
    .clk      (clk),
    .ctl      (stk_gated),
    .top_kind (top_kind)
  );

  // a bare number at top level is complete when the document ends
  assign doc_ok = !st_next.failed &&
                  ((st_next.mode == MD_DONE) ||
                   ((level_next == '0) &&
                    ((st_next.mode == MD_N_ZERO) || (st_next.mode == MD_N_INT) ||
                     (st_next.mode == MD_N_FRAC) || (st_next.mode == MD_N_EXPDIG))));

  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= PSTATE_RST;
      level <= '0;
    end else if (accept) begin
      if (s_tlast) begin
        st    <= PSTATE_RST;
        level <= '0;
      end else begin
        st    <= st_next;
        level <= level_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept && s_tlast) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && s_tlast) begin
      res_bit <= doc_ok;
    end
  end

  assign m_tdata = {7'd0, res_bit};

endmodule

// File: sv/jsv_stack.sv
module jsv_stack #(
  parameter int MAX_DEPTH = jsv_pkg::MAX_DEPTH_DEF
) (
  input  logic              clk,
  input  jsv_pkg::stk_ctl_t ctl,
  output logic              top_kind
);
  import jsv_pkg::*;

  localparam int SLOTS = MAX_DEPTH + 1;

  // shift line, entry 0 is the innermost open container
  logic [SLOTS-1:0] kinds;

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      kinds <= {kinds[SLOTS-2:0], ctl.kind};
    end else if (ctl.pop) begin
      kinds <= {1'b0, kinds[SLOTS-1:1]};
    end
  end

  assign top_kind = kinds[0];

endmodule

// File: sv/jsv_parse.sv
module jsv_parse #(
  parameter int MAX_DEPTH = jsv_pkg::MAX_DEPTH_DEF
) (
  input  jsv_pkg::pstate_t                st,
  input  logic [$clog2(MAX_DEPTH+2)-1:0]  level,
  input  logic                            top_kind,
  input  logic [7:0]                      c,
  output jsv_pkg::pstate_t                st_next,
  output logic [$clog2(MAX_DEPTH+2)-1:0]  level_next,
  output jsv_pkg::stk_ctl_t               stk
);
  import jsv_pkg::*;

  localparam int LVL_W = $clog2(MAX_DEPTH + 2);

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UE     = 8'h45;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LB     = 8'h62;
  localparam logic [7:0] CH_LE     = 8'h65;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_LN     = 8'h6E;
  localparam logic [7:0] CH_LR     = 8'h72;
  localparam logic [7:0] CH_LT     = 8'h74;
  localparam logic [7:0] CH_LU     = 8'h75;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  function automatic logic [7:0] lit_char(input lit_kind_t kind, input logic [2:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    case (kind)
      LIT_TRUE: begin
        case (idx)
          3'd0: ch = "t";
          3'd1: ch = "r";
          3'd2: ch = "u";
          3'd3: ch = "e";
          default: ch = 8'h00;
        endcase
      end
      LIT_FALSE: begin
        case (idx)
          3'd0: ch = "f";
          3'd1: ch = "a";
          3'd2: ch = "l";
          3'd3: ch = "s";
          3'd4: ch = "e";
          default: ch = 8'h00;
        endcase
      end
      LIT_NULL: begin
        case (idx)
          3'd0: ch = "n";
          3'd1: ch = "u";
          3'd2: ch = "l";
          3'd3: ch = "l";
          default: ch = 8'h00;
        endcase
      end
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [2:0] lit_last(input lit_kind_t kind);
    return (kind == LIT_FALSE) ? 3'd4 : 3'd3;
  endfunction

  logic             is_ws;
  logic             is_dig;
  logic             is_hex;
  logic             is_esc;
  logic             is_exp;
  logic             lvl_zero;
  logic [LVL_W-1:0] lvl_dec;
  logic             too_deep;
  logic             top_obj;
  mode_t            fin_mode;
  mode_t            close_mode;

  assign is_ws  = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  assign is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_hex = is_dig || (c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF);
  assign is_esc = (c == CH_QUOTE) || (c == CH_BSLASH) || (c == CH_SLASH) || (c == CH_LB) ||
                  (c == CH_LF) || (c == CH_LN) || (c == CH_LR) || (c == CH_LT);
  assign is_exp = (c == CH_LE) || (c == CH_UE);

  assign lvl_zero   = (level == '0);
  assign lvl_dec    = level - 1'b1;
  assign too_deep   = level > LVL_W'(MAX_DEPTH);
  assign top_obj    = !lvl_zero && top_kind;
  assign fin_mode   = lvl_zero ? MD_DONE : MD_AFTER;
  assign close_mode = (lvl_dec == '0) ? MD_DONE : MD_AFTER;

  always_comb begin
    logic do_begin;
    logic do_after;
    logic do_close;
    logic key;
    do_begin   = 1'b0;
    do_after   = 1'b0;
    do_close   = 1'b0;
    key        = 1'b0;
    st_next    = st;
    level_next = level;
    stk        = '0;

    if (!st.failed) begin
      case (st.mode)
        MD_TOP, MD_VAL: do_begin = 1'b1;
        MD_ARR_FIRST: begin
          if (c == CH_RBRACK) do_close = 1'b1;
          else do_begin = 1'b1;
        end
        MD_OBJ_FIRST, MD_OBJ_KEY: begin
          if (!is_ws) begin
            if (c == CH_QUOTE) st_next.mode = MD_STR_KEY;
            else if (c == CH_RBRACE && st.mode == MD_OBJ_FIRST) do_close = 1'b1;
            else st_next.failed = 1'b1;
          end
        end
        MD_COLON: begin
          if (!is_ws) begin
            if (c == CH_COLON) st_next.mode = MD_VAL;
            else st_next.failed = 1'b1;
          end
        end
        MD_AFTER, MD_DONE: do_after = 1'b1;
        MD_STR_VAL, MD_STR_KEY: begin
          key = (st.mode == MD_STR_KEY);
          if (c == CH_QUOTE) st_next.mode = key ? MD_COLON : fin_mode;
          else if (c < CH_SPACE) st_next.failed = 1'b1;
          else if (c == CH_BSLASH) st_next.mode = key ? MD_ESC_KEY : MD_ESC_VAL;
        end
        MD_ESC_VAL, MD_ESC_KEY: begin
          key = (st.mode == MD_ESC_KEY);
          if (is_esc) begin
            st_next.mode = key ? MD_STR_KEY : MD_STR_VAL;
          end else if (c == CH_LU) begin
            st_next.sub  = 3'd0;
            st_next.mode = key ? MD_HEX_KEY : MD_HEX_VAL;
          end else begin
            st_next.failed = 1'b1;
          end
        end
        MD_HEX_VAL, MD_HEX_KEY: begin
          key = (st.mode == MD_HEX_KEY);
          if (!is_hex) begin
            st_next.failed = 1'b1;
          end else if (st.sub == 3'd3) begin
            st_next.sub  = 3'd0;
            st_next.mode = key ? MD_STR_KEY : MD_STR_VAL;
          end else begin
            st_next.sub = st.sub + 3'd1;
          end
        end
        MD_LIT: begin
          if (st.lit == LIT_TRUE || st.lit == LIT_FALSE || st.lit == LIT_NULL) begin
            if (lit_char(st.lit, st.sub) != c) begin
              st_next.failed = 1'b1;
            end else if (st.sub == lit_last(st.lit)) begin
              st_next.sub  = 3'd0;
              st_next.mode = fin_mode;
            end else begin
              st_next.sub = st.sub + 3'd1;
            end
          end else begin
            st_next.failed = 1'b1;
          end
        end
        MD_N_MINUS: begin
          if (c == CH_ZERO) st_next.mode = MD_N_ZERO;
          else if (is_dig) st_next.mode = MD_N_INT;
          else st_next.failed = 1'b1;
        end
        MD_N_ZERO, MD_N_INT: begin
          if (st.mode == MD_N_INT && is_dig) st_next.mode = MD_N_INT;
          else if (c == CH_DOT) st_next.mode = MD_N_DOT;
          else if (is_exp) st_next.mode = MD_N_EXP;
          else do_after = 1'b1;
        end
        MD_N_DOT: begin
          if (is_dig) st_next.mode = MD_N_FRAC;
          else st_next.failed = 1'b1;
        end
        MD_N_FRAC: begin
          if (is_dig) st_next.mode = MD_N_FRAC;
          else if (is_exp) st_next.mode = MD_N_EXP;
          else do_after = 1'b1;
        end
        MD_N_EXP: begin
          if (c == CH_PLUS || c == CH_MINUS) st_next.mode = MD_N_EXPSIGN;
          else if (is_dig) st_next.mode = MD_N_EXPDIG;
          else st_next.failed = 1'b1;
        end
        MD_N_EXPSIGN: begin
          if (is_dig) st_next.mode = MD_N_EXPDIG;
          else st_next.failed = 1'b1;
        end
        MD_N_EXPDIG: begin
          if (!is_dig) do_after = 1'b1;
        end
        default: st_next.failed = 1'b1;
      endcase
    end

    if (do_begin && !is_ws) begin
      if (too_deep) begin
        st_next.failed = 1'b1;
      end else if (c == CH_LBRACE || c == CH_LBRACK) begin
        stk.push     = 1'b1;
        stk.kind     = (c == CH_LBRACE);
        level_next   = level + 1'b1;
        st_next.mode = (c == CH_LBRACE) ? MD_OBJ_FIRST : MD_ARR_FIRST;
      end else if (c == CH_QUOTE) begin
        st_next.mode = MD_STR_VAL;
      end else if (c == CH_LT || c == CH_LF || c == CH_LN) begin
        st_next.lit  = (c == CH_LT) ? LIT_TRUE : (c == CH_LF) ? LIT_FALSE : LIT_NULL;
        st_next.sub  = 3'd1;
        st_next.mode = MD_LIT;
      end else if (c == CH_MINUS) begin
        st_next.mode = MD_N_MINUS;
      end else if (c == CH_ZERO) begin
        st_next.mode = MD_N_ZERO;
      end else if (is_dig) begin
        st_next.mode = MD_N_INT;
      end else begin
        st_next.failed = 1'b1;
      end
    end

    // a number's terminator lands here too, after the number counts as complete
    if (do_after) begin
      if (is_ws) st_next.mode = fin_mode;
      else if (lvl_zero) st_next.failed = 1'b1;
      else if (c == CH_COMMA) st_next.mode = top_obj ? MD_OBJ_KEY : MD_VAL;
      else if ((c == CH_RBRACK && !top_obj) || (c == CH_RBRACE && top_obj)) do_close = 1'b1;
      else st_next.failed = 1'b1;
    end

    if (do_close) begin
      stk.pop      = 1'b1;
      level_next   = lvl_dec;
      st_next.mode = close_mode;
    end
  end

endmodule

// File: sv/jsv_checker.sv
module jsv_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       s_tlast,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

`include "json_syntax_validator_core_assert.svh"

  logic in_last;
  logic out_wait;

  assign in_last  = s_tvalid && s_tready && s_tlast;
  assign out_wait = m_tvalid && !m_tready;

  // result beat must hold while stalled
  `JSV_ASSERT_NEXT(a_out_hold, out_wait, m_tvalid && $stable(m_tdata), "result changed in stall")

  // last byte of a document yields a result beat in the next cycle
  `JSV_ASSERT_NEXT(a_res_follows_last, in_last, m_tvalid, "no result after last byte")

  // a pending result blocks input, so it cannot be overwritten
  `JSV_ASSERT_NOW(a_no_overrun, out_wait, !s_tready, "input taken over pending result")

  // only the flag bit of the result carries data
  `JSV_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[7:1] == 7'd0, "result padding not zero")

  // no result beat appears without a last byte before it
  `JSV_ASSERT_NEXT(a_no_spurious, !m_tvalid && !in_last, !m_tvalid, "result without last byte")

endmodule

bind json_syntax_validator_core jsv_checker u_jsv_checker (.*);
